// File: hdl/shs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// shs_pkg
// Types, constants and round functions shared by the SHA-256 stream hasher.
// ---------------------------------------------------------------------------
package shs_pkg;

   localparam int CountWidth = 61;
   localparam logic [CountWidth-1:0] COUNT_MAX = {CountWidth{1'b1}};
   localparam logic [5:0] LAST_PAD_POS = 6'd55;
   localparam logic [7:0] PAD_BYTE = 8'h80;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_number;
      logic        final_word;
      logic        length_error;
   } rsp_type;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] small_s0(input logic [31:0] x);
      small_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_s1(input logic [31:0] x);
      small_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic logic [31:0] big_s0(input logic [31:0] x);
      big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] big_s1(input logic [31:0] x);
      big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic logic [31:0] put_byte(input logic [31:0] word, input logic [1:0] pos,
                                            input logic [7:0] value);
      logic [31:0] r;
      r = word;
      case (pos)
         2'd0: r[31:24] = value;
         2'd1: r[23:16] = value;
         2'd2: r[15:8]  = value;
         default: r[7:0] = value;
      endcase
      put_byte = r;
   endfunction

   function automatic logic [31:0] init_hash(input logic [2:0] idx);
      case (idx)
         3'd0: init_hash = 32'h6a09e667;
         3'd1: init_hash = 32'hbb67ae85;
         3'd2: init_hash = 32'h3c6ef372;
         3'd3: init_hash = 32'ha54ff53a;
         3'd4: init_hash = 32'h510e527f;
         3'd5: init_hash = 32'h9b05688c;
         3'd6: init_hash = 32'h1f83d9ab;
         default: init_hash = 32'h5be0cd19;
      endcase
   endfunction

   function automatic logic [31:0] round_key(input logic [5:0] idx);
      case (idx)
         6'd0:  round_key = 32'h428a2f98;  6'd1:  round_key = 32'h71374491;
         6'd2:  round_key = 32'hb5c0fbcf;  6'd3:  round_key = 32'he9b5dba5;
         6'd4:  round_key = 32'h3956c25b;  6'd5:  round_key = 32'h59f111f1;
         6'd6:  round_key = 32'h923f82a4;  6'd7:  round_key = 32'hab1c5ed5;
         6'd8:  round_key = 32'hd807aa98;  6'd9:  round_key = 32'h12835b01;
         6'd10: round_key = 32'h243185be;  6'd11: round_key = 32'h550c7dc3;
         6'd12: round_key = 32'h72be5d74;  6'd13: round_key = 32'h80deb1fe;
         6'd14: round_key = 32'h9bdc06a7;  6'd15: round_key = 32'hc19bf174;
         6'd16: round_key = 32'he49b69c1;  6'd17: round_key = 32'hefbe4786;
         6'd18: round_key = 32'h0fc19dc6;  6'd19: round_key = 32'h240ca1cc;
         6'd20: round_key = 32'h2de92c6f;  6'd21: round_key = 32'h4a7484aa;
         6'd22: round_key = 32'h5cb0a9dc;  6'd23: round_key = 32'h76f988da;
         6'd24: round_key = 32'h983e5152;  6'd25: round_key = 32'ha831c66d;
         6'd26: round_key = 32'hb00327c8;  6'd27: round_key = 32'hbf597fc7;
         6'd28: round_key = 32'hc6e00bf3;  6'd29: round_key = 32'hd5a79147;
         6'd30: round_key = 32'h06ca6351;  6'd31: round_key = 32'h14292967;
         6'd32: round_key = 32'h27b70a85;  6'd33: round_key = 32'h2e1b2138;
         6'd34: round_key = 32'h4d2c6dfc;  6'd35: round_key = 32'h53380d13;
         6'd36: round_key = 32'h650a7354;  6'd37: round_key = 32'h766a0abb;
         6'd38: round_key = 32'h81c2c92e;  6'd39: round_key = 32'h92722c85;
         6'd40: round_key = 32'ha2bfe8a1;  6'd41: round_key = 32'ha81a664b;
         6'd42: round_key = 32'hc24b8b70;  6'd43: round_key = 32'hc76c51a3;
         6'd44: round_key = 32'hd192e819;  6'd45: round_key = 32'hd6990624;
         6'd46: round_key = 32'hf40e3585;  6'd47: round_key = 32'h106aa070;
         6'd48: round_key = 32'h19a4c116;  6'd49: round_key = 32'h1e376c08;
         6'd50: round_key = 32'h2748774c;  6'd51: round_key = 32'h34b0bcb5;
         6'd52: round_key = 32'h391c0cb3;  6'd53: round_key = 32'h4ed8aa4a;
         6'd54: round_key = 32'h5b9cca4f;  6'd55: round_key = 32'h682e6ff3;
         6'd56: round_key = 32'h748f82ee;  6'd57: round_key = 32'h78a5636f;
         6'd58: round_key = 32'h84c87814;  6'd59: round_key = 32'h8cc70208;
         6'd60: round_key = 32'h90befffa;  6'd61: round_key = 32'ha4506ceb;
         6'd62: round_key = 32'hbef9a3f7;  default: round_key = 32'hc67178f2;
      endcase
   endfunction

endpackage
`default_nettype wire

// File: hdl/shs_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// shs_ram
// Single write port, single read port synchronous RAM, registered read data.
// ---------------------------------------------------------------------------
module shs_ram #(
   parameter int Depth = 16,
   parameter int Width = 32,
   localparam int AddrWidth = $clog2(Depth)
) (
   input  wire                  clock,
   input  wire                  wr_en,
   input  wire [AddrWidth-1:0]  wr_addr,
   input  wire [Width-1:0]      wr_data,
   input  wire                  rd_en,
   input  wire [AddrWidth-1:0]  rd_addr,
   output logic [Width-1:0]     rd_data
);

   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// File: hdl/sha256_stream_hasher.sv
// A byte that fills no block and ends no message leaves the hasher idle; a block compression
// runs a load pass, the rounds and an update pass; a digest adds the padding and length writes,
// one or two compressions, then a chain read and an output beat per digest word plus any output stall.
// Throughput is set by the one-round-per-cycle loop, fed from the block and chain memories.
// Reset: synchronous; a clearing pass then writes the block memory to zero and the
// chain memory to the initial hash value before the first byte is taken.
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sha256_stream_hasher
// SHA-256 over a byte stream, block and chain value held in RAM.
// ---------------------------------------------------------------------------
module sha256_stream_hasher
   import shs_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   input  wire          req_valid,
   output logic         req_stall,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire          rsp_stall,
   output rsp_type      rsp_payload
);

   localparam logic [3:0] ST_INIT   = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_LOAD   = 4'd2;
   localparam logic [3:0] ST_ROUND  = 4'd3;
   localparam logic [3:0] ST_UPDATE = 4'd4;
   localparam logic [3:0] ST_PAD    = 4'd5;
   localparam logic [3:0] ST_LEN_HI = 4'd6;
   localparam logic [3:0] ST_LEN_LO = 4'd7;
   localparam logic [3:0] ST_DREAD  = 4'd8;
   localparam logic [3:0] ST_DOUT   = 4'd9;

   logic [3:0] state_ff, state_in, ret_ff, ret_in;
   logic [6:0] cnt_ff, cnt_in;
   logic fin_ff, fin_in, ovf_ff, ovf_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] var_ff [8];
   logic [31:0] var_in [8];
   logic [31:0] w_ff [16];
   logic [31:0] w_in [16];

   logic        buf_we, buf_re, chn_we, chn_re;
   logic [3:0]  buf_waddr, buf_raddr;
   logic [2:0]  chn_waddr, chn_raddr;
   logic [31:0] buf_wdata, buf_rdata, chn_wdata, chn_rdata;

   shs_ram #(.Depth(16), .Width(32)) u_block (
      .clock(clock), .wr_en(buf_we), .wr_addr(buf_waddr), .wr_data(buf_wdata),
      .rd_en(buf_re), .rd_addr(buf_raddr), .rd_data(buf_rdata)
   );

   shs_ram #(.Depth(8), .Width(32)) u_chain (
      .clock(clock), .wr_en(chn_we), .wr_addr(chn_waddr), .wr_data(chn_wdata),
      .rd_en(chn_re), .rd_addr(chn_raddr), .rd_data(chn_rdata)
   );

   logic        accept;
   logic [5:0]  pos;
   logic [31:0] t1, t2, wnew, byte_word, pad_word;
   logic [2:0]  upd_idx;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = (state_ff == ST_DOUT);
   assign pos       = count_ff[5:0];
   assign upd_idx   = 3'(cnt_ff - 7'd1);

   always_comb begin
      rsp_payload.digest_word  = chn_rdata;
      rsp_payload.word_number  = cnt_ff[2:0];
      rsp_payload.final_word   = (cnt_ff[2:0] == 3'd7);
      rsp_payload.length_error = ovf_ff;
   end

   assign t1 = var_ff[7] + big_s1(var_ff[4]) + ((var_ff[4] & var_ff[5]) ^ (~var_ff[4] & var_ff[6]))
             + round_key(cnt_ff[5:0]) + w_ff[0];
   assign t2 = big_s0(var_ff[0])
             + ((var_ff[0] & var_ff[1]) ^ (var_ff[0] & var_ff[2]) ^ (var_ff[1] & var_ff[2]));
   assign wnew = w_ff[0] + small_s0(w_ff[1]) + w_ff[9] + small_s1(w_ff[14]);
   assign byte_word = put_byte(acc_ff, pos[1:0], req_payload.data_byte);
   assign pad_word  = put_byte(acc_ff, pos[1:0], PAD_BYTE);

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      cnt_in   = cnt_ff;
      fin_in   = fin_ff;
      ovf_in   = ovf_ff;
      count_in = count_ff;
      acc_in   = acc_ff;
      var_in   = var_ff;
      w_in     = w_ff;
      buf_we = 1'b0; buf_waddr = cnt_ff[3:0]; buf_wdata = '0;
      buf_re = 1'b0; buf_raddr = cnt_ff[3:0];
      chn_we = 1'b0; chn_waddr = cnt_ff[2:0]; chn_wdata = init_hash(cnt_ff[2:0]);
      chn_re = 1'b0; chn_raddr = cnt_ff[2:0];
      case (state_ff)
         ST_INIT: begin
            buf_we = 1'b1;
            chn_we = 1'b1;
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd15) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               fin_in = req_payload.end_of_message;
               if (req_payload.end_of_message) begin
                  state_in = ST_PAD;
               end
               if (req_payload.has_byte) begin
                  if (count_ff == COUNT_MAX) begin
                     ovf_in = 1'b1;
                  end else begin
                     count_in = count_ff + CountWidth'(1);
                     acc_in   = byte_word;
                     if (pos[1:0] == 2'd3) begin
                        buf_we    = 1'b1;
                        buf_waddr = pos[5:2];
                        buf_wdata = byte_word;
                        acc_in    = '0;
                     end
                     if (pos == 6'd63) begin
                        ret_in   = req_payload.end_of_message ? ST_PAD : ST_IDLE;
                        cnt_in   = '0;
                        state_in = ST_LOAD;
                     end
                  end
               end
            end
         end
         ST_PAD: begin
            buf_we    = 1'b1;
            buf_waddr = pos[5:2];
            buf_wdata = pad_word;
            acc_in    = '0;
            if (pos > LAST_PAD_POS) begin
               ret_in   = ST_LEN_HI;
               cnt_in   = '0;
               state_in = ST_LOAD;
            end else begin
               state_in = ST_LEN_HI;
            end
         end
         ST_LEN_HI: begin
            buf_we    = 1'b1;
            buf_waddr = 4'd14;
            buf_wdata = count_ff[60:29];
            state_in  = ST_LEN_LO;
         end
         ST_LEN_LO: begin
            buf_we    = 1'b1;
            buf_waddr = 4'd15;
            buf_wdata = {count_ff[28:0], 3'b000};
            ret_in    = ST_DREAD;
            cnt_in    = '0;
            state_in  = ST_LOAD;
         end
         ST_LOAD: begin
            // read block word and clear it behind the read
            buf_re = (cnt_ff < 7'd16);
            buf_we = (cnt_ff < 7'd16);
            chn_re = (cnt_ff < 7'd8);
            if (cnt_ff >= 7'd1) begin
               for (int i = 0; i < 15; i++) begin
                  w_in[i] = w_ff[i+1];
               end
               w_in[15] = buf_rdata;
            end
            if (cnt_ff >= 7'd1 && cnt_ff <= 7'd8) begin
               var_in[upd_idx] = chn_rdata;
            end
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd16) begin
               cnt_in   = '0;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            var_in[7] = var_ff[6];
            var_in[6] = var_ff[5];
            var_in[5] = var_ff[4];
            var_in[4] = var_ff[3] + t1;
            var_in[3] = var_ff[2];
            var_in[2] = var_ff[1];
            var_in[1] = var_ff[0];
            var_in[0] = t1 + t2;
            for (int i = 0; i < 15; i++) begin
               w_in[i] = w_ff[i+1];
            end
            w_in[15] = wnew;
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd63) begin
               cnt_in   = '0;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            chn_re = (cnt_ff < 7'd8);
            if (cnt_ff >= 7'd1) begin
               chn_we    = 1'b1;
               chn_waddr = upd_idx;
               chn_wdata = chn_rdata + var_ff[upd_idx];
            end
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd8) begin
               cnt_in   = '0;
               state_in = (ret_ff == ST_IDLE && fin_ff) ? ST_PAD : ret_ff;
            end
         end
         ST_DREAD: begin
            chn_re   = 1'b1;
            chn_we   = 1'b1;
            state_in = ST_DOUT;
         end
         ST_DOUT: begin
            if (!rsp_stall) begin
               if (cnt_ff[2:0] == 3'd7) begin
                  cnt_in   = '0;
                  count_in = '0;
                  ovf_in   = 1'b0;
                  fin_in   = 1'b0;
                  acc_in   = '0;
                  state_in = ST_IDLE;
               end else begin
                  cnt_in   = cnt_ff + 7'd1;
                  state_in = ST_DREAD;
               end
            end
         end
         default: begin
            state_in = ST_INIT;
            cnt_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         ret_ff   <= ST_IDLE;
         cnt_ff   <= '0;
         fin_ff   <= 1'b0;
         ovf_ff   <= 1'b0;
         count_ff <= '0;
         acc_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         cnt_ff   <= cnt_in;
         fin_ff   <= fin_in;
         ovf_ff   <= ovf_in;
         count_ff <= count_in;
         acc_ff   <= acc_in;
      end
      var_ff <= var_in;
      w_ff   <= w_in;
   end

endmodule
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Streams byte messages of many lengths into the hasher, computes each digest
// alongside, and compares every digest word beat with the prediction.
// ---------------------------------------------------------------------------
module tb;
   import shs_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   sha256_stream_hasher dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   localparam logic [31:0] KEYS [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
   localparam logic [31:0] IV [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   logic [31:0]           hash_state [8];
   logic [31:0]           msg_block [16];
   logic [CountWidth-1:0] byte_count;
   logic                  count_overflow;
   rsp_type               digest_queue [$];
   int unsigned           errors = 0;
   int unsigned           beats_sent = 0;
   int unsigned           words_checked = 0;
   int unsigned           digests_sent = 0;
   bit                    hold_off = 1'b0;
   bit                    burst_mode = 1'b1;

   function automatic logic [31:0] ror(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic compress_block();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2, s0, s1;
      for (int i = 0; i < 16; i++) w[i] = msg_block[i];
      for (int i = 16; i < 64; i++) begin
         s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
         s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
         w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      for (int i = 0; i < 8; i++) v[i] = hash_state[i];
      for (int i = 0; i < 64; i++) begin
         t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
              + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KEYS[i] + w[i];
         t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
              + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_state[i] += v[i];
      for (int i = 0; i < 16; i++) msg_block[i] = '0;
   endtask

   function automatic void insert_byte(logic [5:0] pos, logic [7:0] b);
      msg_block[pos[5:2]][{~pos[1:0], 3'b000} +: 8] = b;
   endfunction

   task automatic restart_hash();
      for (int i = 0; i < 8; i++) hash_state[i] = IV[i];
      for (int i = 0; i < 16; i++) msg_block[i] = '0;
      byte_count = '0;
      count_overflow = 1'b0;
   endtask

   task automatic predict_beat(req_type r);
      logic [5:0]   pos;
      logic [63:0]  bits;
      rsp_type      e;
      if (r.has_byte) begin
         if (byte_count == COUNT_MAX) count_overflow = 1'b1;
         else begin
            pos = byte_count[5:0];
            insert_byte(pos, r.data_byte);
            byte_count++;
            if (pos == 6'd63) compress_block();
         end
      end
      if (r.end_of_message) begin
         pos = byte_count[5:0];
         insert_byte(pos, 8'h80);
         if (pos > 6'd55) compress_block();
         bits = {byte_count, 3'b000};
         msg_block[14] = bits[63:32];
         msg_block[15] = bits[31:0];
         compress_block();
         for (int i = 0; i < 8; i++) begin
            e.digest_word = hash_state[i];
            e.word_number = i[2:0];
            e.final_word = (i == 7);
            e.length_error = count_overflow;
            digest_queue.push_back(e);
         end
         digests_sent++;
         restart_hash();
      end
   endtask

   task automatic send_beat(logic [7:0] b, logic h, logic f);
      req_type r;
      r.data_byte = b; r.has_byte = h; r.end_of_message = f;
      predict_beat(r);
      req_valid <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
      if (burst_mode && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end else if (!burst_mode) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic send_message(int unsigned len, bit empty_last);
      for (int i = 0; i < len; i++)
         send_beat(8'($urandom_range(0, 255)), 1'b1, (i == len - 1) && !empty_last);
      if (empty_last || len == 0) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (digest_queue.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic test_empty_message();
      send_beat(8'hff, 1'b0, 1'b1);
      send_beat(8'h00, 1'b0, 1'b1);
      wait_drained();
   endtask

   task automatic test_byte_extremes();
      send_beat(8'h00, 1'b1, 1'b0);
      send_beat(8'hff, 1'b1, 1'b0);
      send_beat(8'h5a, 1'b0, 1'b0);
      send_beat(8'ha5, 1'b1, 1'b1);
      wait_drained();
   endtask

   task automatic test_padding_boundaries();
      send_message(55, 1'b0);
      send_message(56, 1'b0);
      send_message(63, 1'b1);
      send_message(64, 1'b0);
      wait_drained();
   endtask

   task automatic test_backpressure();
      hold_off = 1'b1;
      send_message(5, 1'b0);
      send_message(10, 1'b0);
      wait_drained();
   endtask

   task automatic test_random_messages();
      int unsigned len;
      while (beats_sent < 320) begin
         burst_mode = ($urandom_range(0, 4) != 0);
         case ($urandom_range(0, 5))
            0: len = $urandom_range(0, 3);
            1: len = $urandom_range(52, 66);
            default: len = $urandom_range(1, 40);
         endcase
         for (int i = 0; i < len; i++)
            send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 7) != 0, 1'b0);
         send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
      end
      burst_mode = 1'b1;
      wait_drained();
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (hold_off) rsp_stall <= 1'b1;
         else rsp_stall <= ($urandom_range(0, 3) == 0) && ($urandom_range(0, 1) == 0);
      end
   end

   initial begin
      wait (hold_off);
      repeat (400) @(posedge clock);
      hold_off = 1'b0;
   end

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (digest_queue.size() == 0) begin
            $error("digest word with no expectation: %h", rsp_payload.digest_word);
            errors++;
         end else begin
            e = digest_queue.pop_front();
            words_checked++;
            if (rsp_payload.digest_word !== e.digest_word) begin
               $error("digest_word expected %h got %h", e.digest_word, rsp_payload.digest_word);
               errors++;
            end
            if (rsp_payload.word_number !== e.word_number) begin
               $error("word_number expected %0d got %0d", e.word_number, rsp_payload.word_number);
               errors++;
            end
            if (rsp_payload.final_word !== e.final_word) begin
               $error("final_word expected %b got %b", e.final_word, rsp_payload.final_word);
               errors++;
            end
            if (rsp_payload.length_error !== e.length_error) begin
               $error("length_error expected %b got %b", e.length_error,
                      rsp_payload.length_error);
               errors++;
            end
         end
      end
   end

   initial begin
      restart_hash();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_message();
      test_byte_extremes();
      test_padding_boundaries();
      test_backpressure();
      test_random_messages();
      if (digest_queue.size() != 0) begin
         $error("%0d digest words never arrived", digest_queue.size());
         errors++;
      end
      $display("Sent %0d beats in %0d messages, checked %0d digest words.",
               beats_sent, digests_sent, words_checked);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
